### sv/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement block.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int DEF_MAX_FRAMES = 8;
  localparam int DEF_PAGE_BITS  = 6;

  localparam int          CFG_W         = 4;
  localparam logic [3:0]  FRAME_CNT_RST = 4'd6;

  localparam int          REPL_W   = 16;
  localparam logic [15:0] REPL_MAX = 16'hFFFF;

  // Per-cycle command broadcast along the chain of frame cells.
  typedef struct packed {
    logic shift;   // evicting miss: every cell takes its younger neighbor, the tail the new page
    logic append;  // miss with a free frame: the first free cell loads the page
  } fpr_ctrl_t;

endpackage

### sv/fpr_cell.sv
// One frame cell: holds a page, compares it, and shifts toward the oldest end.
`timescale 1ns / 1ps

module fpr_cell
  import fpr_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int CNT_W     = 4,
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic                 clk,
  input  fpr_ctrl_t            ctrl,
  input  logic [CNT_W-1:0]     count,
  input  logic [PAGE_BITS-1:0] page_in,
  input  logic [PAGE_BITS-1:0] neighbor_page,
  output logic [PAGE_BITS-1:0] page_q,
  output logic                 match
);

  logic active;
  logic is_tail;
  logic is_free;

  // Cells below the resident count hold pages in age order, oldest at index zero.
  assign active  = CNT_W'(IDX) < count;
  assign is_free = CNT_W'(IDX) == count;
  assign is_tail = CNT_W'(IDX) == (count - CNT_W'(1));
  assign match   = active && (page_q == page_in);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      page_q <= is_tail ? page_in : neighbor_page;
    end else if (ctrl.append && is_free) begin
      page_q <= page_in;
    end
  end

endmodule

### sv/fifo_page_replacement.sv
// Top level of the FIFO page replacement block: control, counters and the frame chain.
//
//  Channel   Direction  Signals
//  in        sink       in_valid, in_ready, page
//  out       source     out_valid, out_ready, hit, loaded, evicted_valid, evicted_page,
//                       resident_count, replacement_count
//  cfg       sink       cfg_valid, cfg_ready, frame_count
//
// One page reference per cycle unless a held result stalls the input: the lookup compares
// all cells in parallel and the chain shift, counters and result register all update at
// the accepting edge. The result is registered there and held until taken; a new
// reference is accepted in the same cycle the previous result leaves.
// Reset clears the resident count and counter and sets frame_count to 6; no sweep.
`timescale 1ns / 1ps

module fifo_page_replacement
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = DEF_PAGE_BITS,
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic                 loaded,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [CNT_W-1:0]     resident_count,
  output logic [REPL_W-1:0]    replacement_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     frame_count
);

  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     frame_cfg;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [REPL_W-1:0]    repl;
  logic [REPL_W-1:0]    repl_next;
  logic [CNT_W-1:0]     cap;
  logic [PAGE_BITS-1:0] cell_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_match;
  logic                 in_fire;
  logic                 is_hit;
  logic                 evict;
  fpr_ctrl_t            ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Effective frame limit: zero counts as one, anything above the cell count saturates.
  always_comb begin
    if (frame_cfg == '0) begin
      cap = CNT_W'(1);
    end else if (CMP_W'(frame_cfg) > CMP_W'(MAX_FRAMES)) begin
      cap = CNT_W'(MAX_FRAMES);
    end else begin
      cap = CNT_W'(frame_cfg);
    end
  end

  assign is_hit = |cell_match;
  assign evict  = !is_hit && (count >= cap);

  always_comb begin
    ctrl.shift  = in_fire && evict;
    ctrl.append = in_fire && !is_hit && !evict;
    count_next  = count;
    repl_next   = repl;
    if (ctrl.append) begin
      count_next = count + CNT_W'(1);
    end
    if (ctrl.shift && (repl != REPL_MAX)) begin
      repl_next = repl + REPL_W'(1);
    end
  end

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] nb;
    if (i == MAX_FRAMES - 1) begin : g_last
      assign nb = page;
    end else begin : g_mid
      assign nb = cell_page[i+1];
    end
    fpr_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .count         (count),
      .page_in       (page),
      .neighbor_page (nb),
      .page_q        (cell_page[i]),
      .match         (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cfg <= FRAME_CNT_RST;
      count     <= '0;
      repl      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_cfg <= frame_count;
      end
      count <= count_next;
      repl  <= repl_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hit               <= is_hit;
      loaded            <= !is_hit;
      evicted_valid     <= evict;
      evicted_page      <= evict ? cell_page[0] : '0;
      resident_count    <= count_next;
      replacement_count <= repl_next;
    end
  end

endmodule

### sv/fpr_checker.sv
// Port-level checks for the FIFO page replacement block, bound to the top level.
`timescale 1ns / 1ps

module fpr_checker
  import fpr_pkg::*;
#(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = DEF_PAGE_BITS,
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1)
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic                 loaded,
  input logic                 evicted_valid,
  input logic [PAGE_BITS-1:0] evicted_page,
  input logic [CNT_W-1:0]     resident_count,
  input logic [REPL_W-1:0]    replacement_count
);

  // Every reference is either resident already or brought in, never both.
  a_hit_xor_load: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit != loaded))
    else $error("hit and loaded disagree");

  // An eviction only happens on a miss; without one the page field reads zero.
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!evicted_valid && evicted_page == '0) || (evicted_valid && loaded)))
    else $error("eviction fields inconsistent");

  // The resident count cannot exceed the number of frame cells.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(resident_count) <= 32'(MAX_FRAMES)))
    else $error("resident count beyond frame cells");

  // A stalled result transfer keeps its resident and replacement counts.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(replacement_count) && $stable(resident_count)))
    else $error("result changed while stalled");

endmodule

bind fifo_page_replacement fpr_checker #(
  .MAX_FRAMES (MAX_FRAMES),
  .PAGE_BITS  (PAGE_BITS)
) u_fpr_checker (.*);
